// ===== design/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants for the calendar date counter
// Transaction structs, sequencer states, month table and leap-year helpers.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam int YEAR_BITS    = 16;
   localparam int ADVANCE_BITS = 10;
   localparam int MONTH_BITS   = 4;
   localparam int DAY_BITS     = 5;

   // Year held modulo the Gregorian cycle of 400 years
   localparam int LEAP_CYCLE   = 400;
   localparam int MOD_BITS     = $clog2(LEAP_CYCLE);
   localparam int CENTURY      = 100;
   localparam int MONTHS       = 12;
   localparam int FEB          = 2;
   localparam int FEB_LEAP_LEN = 29;

   localparam logic [YEAR_BITS-1:0]  RESET_YEAR  = YEAR_BITS'(2000);
   localparam logic [MOD_BITS-1:0]   RESET_MOD   = MOD_BITS'(2000 % LEAP_CYCLE);
   localparam logic [MONTH_BITS-1:0] RESET_MONTH = MONTH_BITS'(1);
   localparam logic [DAY_BITS-1:0]   RESET_DAY   = DAY_BITS'(1);

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  opcode;
      logic [YEAR_BITS-1:0]    load_year;
      logic [MONTH_BITS-1:0]   load_month;
      logic [DAY_BITS-1:0]     load_day;
      logic [ADVANCE_BITS-1:0] advance_days;
   } req_type;

   typedef struct packed {
      logic [YEAR_BITS-1:0]  out_year;
      logic [MONTH_BITS-1:0] out_month;
      logic [DAY_BITS-1:0]   out_day;
      logic                  load_error;
   } rsp_type;

   typedef struct packed {
      logic [YEAR_BITS-1:0]  year;
      logic [MOD_BITS-1:0]   year_mod;
      logic [MONTH_BITS-1:0] month;
      logic [DAY_BITS-1:0]   day;
   } date_type;

   typedef struct packed {
      logic [DAY_BITS-1:0] month_len;
      date_type            next;
   } step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMAINDER,
      ST_ADVANCE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      REM_IDLE,
      REM_MULTIPLY,
      REM_SCALE,
      REM_SUBTRACT
   } rem_phase_type;

   typedef struct packed {
      logic accept;
      logic rem_start;
      logic sel_load;
      logic load_check;
      logic step_en;
      logic out_load;
   } ctrl_type;

   // Non-leap month lengths; zero for codes that are not a month
   function automatic logic [DAY_BITS-1:0] base_month_len(input logic [MONTH_BITS-1:0] m);
      logic [DAY_BITS-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_BITS'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_BITS'(30);
         4'd2:                                       len = DAY_BITS'(28);
         default:                                    len = '0;
      endcase
      return len;
   endfunction

   // The low two year bits match the 400-year remainder modulo 4
   function automatic logic is_leap(input logic [YEAR_BITS-1:0] y,
                                    input logic [MOD_BITS-1:0]  ym);
      logic by400;
      logic by100;
      by400 = (ym == '0);
      by100 = by400 || (ym == MOD_BITS'(CENTURY)) || (ym == MOD_BITS'(2 * CENTURY)) ||
              (ym == MOD_BITS'(3 * CENTURY));
      return by400 || ((y[1:0] == 2'b00) && !by100);
   endfunction

endpackage

// ===== design/cda_mod400.sv =====
// ----------------------------------------------------------------------------
// cda_mod400: year remainder unit
// Reduces a loaded year modulo 400 by a reciprocal multiply for the quotient,
// a scale back by 400 and a subtract.
// ----------------------------------------------------------------------------
module cda_mod400 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cda_pkg::YEAR_BITS-1:0] value,
   output logic                          done,
   output logic [cda_pkg::MOD_BITS-1:0]  remainder
);
   import cda_pkg::*;

   // 400 is 25 shifted by 4: divide the upper year bits by 25
   localparam int     CYCLE_SHIFT = 4;
   localparam int     CYCLE_ODD   = LEAP_CYCLE >> CYCLE_SHIFT;
   localparam int     HI_BITS     = YEAR_BITS - CYCLE_SHIFT;
   localparam int     RECIP_SHIFT = HI_BITS + 5;
   localparam int     RECIP_BITS  = HI_BITS + 1;
   localparam int     PROD_BITS   = HI_BITS + RECIP_BITS;
   localparam int     Q_BITS      = PROD_BITS - RECIP_SHIFT;
   localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + longint'(CYCLE_ODD - 1)) /
                                    longint'(CYCLE_ODD);

   rem_phase_type        phase_ff, phase_in;
   logic [YEAR_BITS-1:0] value_ff, value_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [YEAR_BITS-1:0] sub_ff, sub_in;
   logic [MOD_BITS-1:0]  rem_ff, rem_in;
   logic                 done_ff, done_in;
   logic [Q_BITS-1:0]    quot;
   logic [YEAR_BITS-1:0] diff;

   assign quot = prod_ff[PROD_BITS-1:RECIP_SHIFT];
   assign diff = value_ff - sub_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         phase_in = REM_MULTIPLY;
      end else begin
         case (phase_ff)
            REM_MULTIPLY: phase_in = REM_SCALE;
            REM_SCALE:    phase_in = REM_SUBTRACT;
            REM_SUBTRACT: phase_in = REM_IDLE;
            default:      phase_in = REM_IDLE;
         endcase
      end
   end

   // Datapath
   always_comb begin
      value_in = value_ff;
      prod_in  = prod_ff;
      sub_in   = sub_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      if (start) begin
         value_in = value;
      end else begin
         case (phase_ff)
            REM_MULTIPLY: begin
               prod_in = PROD_BITS'(value_ff[YEAR_BITS-1:CYCLE_SHIFT]) * PROD_BITS'(RECIP);
            end
            REM_SCALE: begin
               sub_in = YEAR_BITS'(quot) * YEAR_BITS'(LEAP_CYCLE);
            end
            REM_SUBTRACT: begin
               rem_in  = diff[MOD_BITS-1:0];
               done_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= REM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      value_ff <= value_in;
      prod_ff  <= prod_in;
      sub_ff   <= sub_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/cda_day_step.sv =====
// ----------------------------------------------------------------------------
// cda_day_step: shared one-day date unit
// Gives the month length of a date and the date one day later, rolling over
// month and year ends and carrying the 400-year remainder along.
// ----------------------------------------------------------------------------
module cda_day_step (
   input  cda_pkg::date_type cur,
   output cda_pkg::step_type step
);
   import cda_pkg::*;

   logic [DAY_BITS-1:0] len;

   always_comb begin
      len = base_month_len(cur.month);
      if ((cur.month == MONTH_BITS'(FEB)) && is_leap(cur.year, cur.year_mod)) begin
         len = DAY_BITS'(FEB_LEAP_LEN);
      end
      step.month_len = len;
      step.next      = cur;
      if (cur.day < len) begin
         step.next.day = cur.day + DAY_BITS'(1);
      end else if (cur.month < MONTH_BITS'(MONTHS)) begin
         step.next.month = cur.month + MONTH_BITS'(1);
         step.next.day   = DAY_BITS'(1);
      end else begin
         // wrap past the top year restarts the cycle at year zero
         step.next.year  = cur.year + YEAR_BITS'(1);
         step.next.month = MONTH_BITS'(1);
         step.next.day   = DAY_BITS'(1);
         if ((cur.year == '1) || (cur.year_mod == MOD_BITS'(LEAP_CYCLE - 1))) begin
            step.next.year_mod = '0;
         end else begin
            step.next.year_mod = cur.year_mod + MOD_BITS'(1);
         end
      end
   end

endmodule

// ===== design/calendar_date_advance.sv =====
// ----------------------------------------------------------------------------
// calendar_date_advance: Gregorian calendar date counter
// Holds a date, loads a checked date or advances it by a count of days.
// ----------------------------------------------------------------------------
// Every request transaction gives one response transaction with the date as
// it stands afterwards. The date resets to 2000-01-01. A new request is taken
// only after the response of the last one is loaded into the output register.
// A load reduces the year modulo 400 by a reciprocal multiply before the date
// is checked; an advance moves the date one day per cycle through the shared
// day-step unit. A rejected load leaves the date as it is and flags
// load_error. Requests are held off while one is in progress; a finished
// response waits in the output register.
module calendar_date_advance (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cda_pkg::rsp_type rsp_data
);
   import cda_pkg::*;

   state_type               state_ff, state_in;
   ctrl_type                ctrl;
   req_type                 req_ff;
   logic [ADVANCE_BITS-1:0] count_ff, count_in;
   date_type                date_ff, date_in;
   logic                    err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;

   logic                    rem_done;
   logic [MOD_BITS-1:0]     rem_value;
   date_type                step_cur;
   step_type                step;
   logic                    load_ok;

   cda_mod400 u_mod400 (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.rem_start),
      .value     (req_data.load_year),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      if (ctrl.sel_load) begin
         step_cur.year     = req_ff.load_year;
         step_cur.year_mod = rem_value;
         step_cur.month    = req_ff.load_month;
         step_cur.day      = req_ff.load_day;
      end else begin
         step_cur = date_ff;
      end
   end

   cda_day_step u_day_step (
      .cur  (step_cur),
      .step (step)
   );

   assign load_ok = (step.month_len != '0) && (req_ff.load_day != '0) &&
                    (req_ff.load_day <= step.month_len);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_LOAD) begin
                  state_in = ST_REMAINDER;
               end else if (req_data.advance_days == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ADVANCE;
               end
            end
         end
         ST_REMAINDER: begin
            if (rem_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_ADVANCE: begin
            if (count_ff == ADVANCE_BITS'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctrl      = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            ctrl.accept    = req_valid;
            ctrl.rem_start = req_valid && (req_data.opcode == OP_LOAD);
         end
         ST_REMAINDER: begin
            ctrl.sel_load   = 1'b1;
            ctrl.load_check = rem_done;
         end
         ST_ADVANCE: begin
            ctrl.step_en = 1'b1;
         end
         ST_FINISH: begin
            ctrl.out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      date_in      = date_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.accept) begin
         count_in = req_data.advance_days;
         err_in   = 1'b0;
      end
      if (ctrl.load_check) begin
         if (load_ok) begin
            date_in.year     = req_ff.load_year;
            date_in.year_mod = rem_value;
            date_in.month    = req_ff.load_month;
            date_in.day      = req_ff.load_day;
         end else begin
            err_in = 1'b1;
         end
      end
      if (ctrl.step_en) begin
         date_in  = step.next;
         count_in = count_ff - ADVANCE_BITS'(1);
      end
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         date_ff.year     <= RESET_YEAR;
         date_ff.year_mod <= RESET_MOD;
         date_ff.month    <= RESET_MONTH;
         date_ff.day      <= RESET_DAY;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         date_ff      <= date_in;
      end
      count_ff <= count_in;
      err_ff   <= err_in;
      if (ctrl.accept) begin
         req_ff <= req_data;
      end
      // hold the response while the far side stalls
      if (ctrl.out_load) begin
         rsp_ff.out_year   <= date_ff.year;
         rsp_ff.out_month  <= date_ff.month;
         rsp_ff.out_day    <= date_ff.day;
         rsp_ff.load_error <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
